// ===== design/pressure_sensor_compensation_assert.svh =====
// Assertion macros shared by the compensation pipeline modules.
`ifndef PRESSURE_SENSOR_COMPENSATION_ASSERT_SVH
`define PRESSURE_SENSOR_COMPENSATION_ASSERT_SVH

`ifndef SYNTHESIS

`define PSC_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("psc: same-cycle check failed");

`define PSC_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("psc: next-cycle check failed");

`else

`define PSC_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons)

`define PSC_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons)

`endif

`endif

// ===== design/psc_pkg.sv =====
// Types and constants of the pressure sensor compensation block.
package psc_pkg;

  localparam int RAW_W      = 24;
  localparam int TEMP_W     = 16;
  localparam int PRESS_W    = 25;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int OFF_W      = 38;
  localparam int SENS_W     = 37;

  localparam logic signed [TEMP_W-1:0]  TEMP_HI  = 16'sh7FFF;
  localparam logic signed [TEMP_W-1:0]  TEMP_LO  = 16'sh8000;
  localparam logic signed [PRESS_W-1:0] PRESS_HI = 25'sh0FFFFFF;
  localparam logic signed [PRESS_W-1:0] PRESS_LO = 25'sh1000000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SENS  = 3'd0,
    REG_OFF   = 3'd1,
    REG_TCS   = 3'd2,
    REG_TCO   = 3'd3,
    REG_TREF  = 3'd4,
    REG_TSENS = 3'd5,
    REG_MODEL = 3'd6
  } psc_reg_t;

  typedef enum logic {
    MODEL_LOW_RANGE  = 1'b0,
    MODEL_HIGH_RANGE = 1'b1
  } psc_model_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] sens;
    logic [CFG_DATA_W-1:0] off;
    logic [CFG_DATA_W-1:0] tcs;
    logic [CFG_DATA_W-1:0] tco;
    logic [CFG_DATA_W-1:0] tref;
    logic [CFG_DATA_W-1:0] tsens;
    psc_model_t            model;
  } psc_cfg_t;

  // Word handed from the temperature half to the pressure half.
  typedef struct packed {
    logic [RAW_W-1:0]          pressure_raw;
    logic signed [TEMP_W-1:0]  temperature;
    logic signed [OFF_W-1:0]   off;
    logic signed [SENS_W-1:0]  sens;
  } psc_mid_t;

endpackage

// ===== design/psc_in_if.sv =====
// Input channel: one raw pressure and temperature conversion pair per word.
interface psc_in_if;
  logic        valid;
  logic        ready;
  logic [23:0] pressure_raw;
  logic [23:0] temp_raw;

  modport source (output valid, output pressure_raw, output temp_raw, input ready);
  modport sink (input valid, input pressure_raw, input temp_raw, output ready);
endinterface

// ===== design/psc_out_if.sv =====
// Output channel: one compensated temperature and pressure per word.
interface psc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] temperature;
  logic signed [24:0] pressure;

  modport source (output valid, output temperature, output pressure, input ready);
  modport sink (input valid, input temperature, input pressure, output ready);
endinterface

// ===== design/psc_cfg_regs.sv =====
// Calibration word and model select register file.
module psc_cfg_regs import psc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output psc_cfg_t              cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sens  <= '0;
      cfg.off   <= '0;
      cfg.tcs   <= '0;
      cfg.tco   <= '0;
      cfg.tref  <= '0;
      cfg.tsens <= '0;
      cfg.model <= MODEL_LOW_RANGE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SENS:  cfg.sens  <= cfg_data;
        REG_OFF:   cfg.off   <= cfg_data;
        REG_TCS:   cfg.tcs   <= cfg_data;
        REG_TCO:   cfg.tco   <= cfg_data;
        REG_TREF:  cfg.tref  <= cfg_data;
        REG_TSENS: cfg.tsens <= cfg_data;
        REG_MODEL: cfg.model <= psc_model_t'(cfg_data[0]);
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== design/psc_temp_pipe.sv =====
// Temperature half: dT, first-order terms, second-order corrections, temperature.
`include "pressure_sensor_compensation_assert.svh"
module psc_temp_pipe import psc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  psc_cfg_t cfg,
  psc_in_if.sink   sample,
  output logic     mid_valid,
  input  logic     mid_ready,
  output psc_mid_t mid
);

  localparam int NSTG = 5;

  logic [NSTG-1:0] v;
  logic [NSTG-1:0] en;
  logic [NSTG-1:0] v_in;
  logic            big;

  assign big = (cfg.model == MODEL_HIGH_RANGE);

  // A stage may load when it is empty or when the stage after it moves.
  always_comb begin
    en[NSTG-1] = !v[NSTG-1] || mid_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign v_in         = {v[NSTG-2:0], sample.valid};
  assign sample.ready = en[0];
  assign mid_valid    = v[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (en[k]) begin
          v[k] <= v_in[k];
        end
      end
    end
  end

  // Stage 1: dT = D2 - C5 * 256.
  logic signed [24:0] dt_next;
  logic signed [24:0] dt_s1;
  logic [RAW_W-1:0]   d1_s1;

  assign dt_next = $signed({1'b0, sample.temp_raw}) - $signed({1'b0, cfg.tref, 8'h00});

  always_ff @(posedge clk) begin
    if (en[0]) begin
      dt_s1 <= dt_next;
      d1_s1 <= sample.pressure_raw;
    end
  end

  // Stage 2: the four products of dT.
  logic signed [40:0] pt_next;
  logic signed [40:0] po_next;
  logic signed [40:0] ps_next;
  logic signed [48:0] dsq_full;
  logic signed [40:0] pt_s2;
  logic signed [40:0] po_s2;
  logic signed [40:0] ps_s2;
  logic [47:0]        dsq_s2;
  logic [RAW_W-1:0]   d1_s2;

  assign pt_next  = dt_s1 * $signed({1'b0, cfg.tsens});
  assign po_next  = dt_s1 * $signed({1'b0, cfg.tco});
  assign ps_next  = dt_s1 * $signed({1'b0, cfg.tcs});
  assign dsq_full = dt_s1 * dt_s1;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      pt_s2  <= pt_next;
      po_s2  <= po_next;
      ps_s2  <= ps_next;
      dsq_s2 <= dsq_full[47:0];
      d1_s2  <= d1_s1;
    end
  end

  // Stage 3: signed divides by powers of two round toward zero, so negative
  // values get a bias of the divisor minus one before the shift.
  logic signed [40:0] pt_b;
  logic signed [40:0] po_b;
  logic signed [40:0] ps_b;
  logic signed [40:0] po_sh;
  logic signed [40:0] ps_sh;
  logic signed [17:0] dtemp_next;
  logic signed [34:0] offt;
  logic signed [33:0] senst;
  logic [32:0]        base_off;
  logic [31:0]        base_sens;
  logic signed [35:0] off1_next;
  logic signed [34:0] sens1_next;
  logic               cold_next;
  logic [51:0]        m11;
  logic [49:0]        m3t;
  logic [16:0]        ti_next;

  assign pt_b       = pt_s2 + (pt_s2[40] ? 41'sd8388607 : 41'sd0);
  assign dtemp_next = pt_b[40:23];
  assign cold_next  = dtemp_next[17];

  assign po_b  = po_s2 + (po_s2[40] ? (big ? 41'sd127 : 41'sd63) : 41'sd0);
  assign po_sh = big ? (po_b >>> 7) : (po_b >>> 6);
  assign offt  = po_sh[34:0];
  assign ps_b  = ps_s2 + (ps_s2[40] ? (big ? 41'sd255 : 41'sd127) : 41'sd0);
  assign ps_sh = big ? (ps_b >>> 8) : (ps_b >>> 7);
  assign senst = ps_sh[33:0];

  assign base_off   = big ? {1'b0, cfg.off, 16'h0000} : {cfg.off, 17'h00000};
  assign base_sens  = big ? {1'b0, cfg.sens, 15'h0000} : {cfg.sens, 16'h0000};
  assign off1_next  = $signed({3'b000, base_off}) + $signed({offt[34], offt});
  assign sens1_next = $signed({3'b000, base_sens}) + $signed({senst[33], senst});

  assign m11 = {1'b0, dsq_s2, 3'b000} + {3'b000, dsq_s2, 1'b0} + {4'b0000, dsq_s2};
  assign m3t = {1'b0, dsq_s2, 1'b0} + {2'b00, dsq_s2};

  always_comb begin
    if (!big) begin
      ti_next = cold_next ? m11[51:35] : '0;
    end else begin
      ti_next = cold_next ? m3t[49:33] : {5'b00000, dsq_s2[47:36]};
    end
  end

  logic signed [17:0] dtemp_s3;
  logic signed [35:0] off1_s3;
  logic signed [34:0] sens1_s3;
  logic [16:0]        ti_s3;
  logic               cold_s3;
  logic [RAW_W-1:0]   d1_s3;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      dtemp_s3 <= dtemp_next;
      off1_s3  <= off1_next;
      sens1_s3 <= sens1_next;
      ti_s3    <= ti_next;
      cold_s3  <= cold_next;
      d1_s3    <= d1_s2;
    end
  end

  // Stage 4: (T - 20.00)^2 and the second-order temperature.
  logic signed [35:0] sq_full;
  logic signed [19:0] t2_next;
  logic [33:0]        sq_s4;
  logic signed [19:0] t2_s4;
  logic signed [35:0] off1_s4;
  logic signed [34:0] sens1_s4;
  logic               cold_s4;
  logic [RAW_W-1:0]   d1_s4;

  assign sq_full = dtemp_s3 * dtemp_s3;
  assign t2_next = $signed({{2{dtemp_s3[17]}}, dtemp_s3}) + 20'sd2000
                 - $signed({3'b000, ti_s3});

  always_ff @(posedge clk) begin
    if (en[3]) begin
      sq_s4    <= sq_full[33:0];
      t2_s4    <= t2_next;
      off1_s4  <= off1_s3;
      sens1_s4 <= sens1_s3;
      cold_s4  <= cold_s3;
      d1_s4    <= d1_s3;
    end
  end

  // Stage 5: offset and sensitivity corrections, temperature saturation.
  logic [38:0]        m31;
  logic [35:0]        m3s;
  logic [39:0]        m63;
  logic [36:0]        m5;
  logic [35:0]        offi;
  logic [34:0]        sensi;
  psc_mid_t           mid_next;

  assign m31 = {sq_s4, 5'b00000} - {5'b00000, sq_s4};
  assign m3s = {1'b0, sq_s4, 1'b0} + {2'b00, sq_s4};
  assign m63 = {sq_s4, 6'b000000} - {6'b000000, sq_s4};
  assign m5  = {1'b0, sq_s4, 2'b00} + {3'b000, sq_s4};

  always_comb begin
    if (!big) begin
      offi  = cold_s4 ? m31[38:3] : '0;
      sensi = cold_s4 ? m63[39:5] : '0;
    end else if (cold_s4) begin
      offi  = {1'b0, m3s[35:1]};
      sensi = {1'b0, m5[36:3]};
    end else begin
      offi  = {6'b000000, sq_s4[33:4]};
      sensi = '0;
    end
  end

  always_comb begin
    mid_next.pressure_raw = d1_s4;
    mid_next.off  = $signed({{2{off1_s4[35]}}, off1_s4}) - $signed({2'b00, offi});
    mid_next.sens = $signed({{2{sens1_s4[34]}}, sens1_s4}) - $signed({2'b00, sensi});
    if (t2_s4 > TEMP_HI) begin
      mid_next.temperature = TEMP_HI;
    end else if (t2_s4 < TEMP_LO) begin
      mid_next.temperature = TEMP_LO;
    end else begin
      mid_next.temperature = t2_s4[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      mid <= mid_next;
    end
  end

  `PSC_ASSERT_IMP(a_low_warm_no_ti, clk, rst, v[2] && !cold_s3 && cfg.model == MODEL_LOW_RANGE, ti_s3 == '0)
  `PSC_ASSERT_NEXT(a_low_warm_off_kept, clk, rst, v[3] && en[4] && !cold_s4 && cfg.model == MODEL_LOW_RANGE, mid.off == $past(off1_s4))
  `PSC_ASSERT_IMP(a_stall_only_full, clk, rst, !en[0], &v)
  `PSC_ASSERT_NEXT(a_first_stage_holds, clk, rst, v[0] && !en[0], v[0] && $stable(dt_s1))

endmodule

// ===== design/psc_press_pipe.sv =====
// Pressure half: D1 * SENS in two partial products, offset, scaling, saturation.
`include "pressure_sensor_compensation_assert.svh"
module psc_press_pipe import psc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  psc_cfg_t cfg,
  input  logic     mid_valid,
  output logic     mid_ready,
  input  psc_mid_t mid,
  psc_out_if.source result
);

  localparam int NSTG = 6;

  logic [NSTG-1:0] v;
  logic [NSTG-1:0] en;
  logic [NSTG-1:0] v_in;
  logic            big;

  assign big = (cfg.model == MODEL_HIGH_RANGE);

  always_comb begin
    en[NSTG-1] = !v[NSTG-1] || result.ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign v_in         = {v[NSTG-2:0], mid_valid};
  assign mid_ready    = en[0];
  assign result.valid = v[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (en[k]) begin
          v[k] <= v_in[k];
        end
      end
    end
  end

  // Stage 1: SENS is split into a signed upper and an unsigned lower part.
  logic [42:0]              pp_lo_next;
  logic signed [41:0]       pp_hi_next;
  logic [42:0]              pp_lo_s1;
  logic signed [41:0]       pp_hi_s1;
  logic signed [OFF_W-1:0]  off_s1;
  logic signed [TEMP_W-1:0] temp_s1;

  assign pp_lo_next = mid.pressure_raw * mid.sens[18:0];
  assign pp_hi_next = $signed({1'b0, mid.pressure_raw}) * $signed(mid.sens[36:19]);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pp_lo_s1 <= pp_lo_next;
      pp_hi_s1 <= pp_hi_next;
      off_s1   <= mid.off;
      temp_s1  <= mid.temperature;
    end
  end

  // Stage 2: full product.
  logic signed [60:0]       prodp_next;
  logic signed [60:0]       prodp_s2;
  logic signed [OFF_W-1:0]  off_s2;
  logic signed [TEMP_W-1:0] temp_s2;

  assign prodp_next = $signed({pp_hi_s1, 19'h00000}) + $signed({18'h00000, pp_lo_s1});

  always_ff @(posedge clk) begin
    if (en[1]) begin
      prodp_s2 <= prodp_next;
      off_s2   <= off_s1;
      temp_s2  <= temp_s1;
    end
  end

  // Stage 3: divide by 2^21, rounding toward zero.
  logic signed [60:0]       pb;
  logic signed [39:0]       q_s3;
  logic signed [OFF_W-1:0]  off_s3;
  logic signed [TEMP_W-1:0] temp_s3;

  assign pb = prodp_s2 + (prodp_s2[60] ? 61'sd2097151 : 61'sd0);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      q_s3    <= pb[60:21];
      off_s3  <= off_s2;
      temp_s3 <= temp_s2;
    end
  end

  // Stage 4: subtract the offset.
  logic signed [40:0]       x_next;
  logic signed [40:0]       x_s4;
  logic signed [TEMP_W-1:0] temp_s4;

  assign x_next = $signed({q_s3[39], q_s3}) - $signed({{3{off_s3[OFF_W-1]}}, off_s3});

  always_ff @(posedge clk) begin
    if (en[3]) begin
      x_s4    <= x_next;
      temp_s4 <= temp_s3;
    end
  end

  // Stage 5: final divide, by 2^15 for the low-range part and 2^13 otherwise.
  logic signed [40:0]       xb;
  logic signed [40:0]       xs;
  logic signed [27:0]       y_s5;
  logic signed [TEMP_W-1:0] temp_s5;

  assign xb = x_s4 + (x_s4[40] ? (big ? 41'sd8191 : 41'sd32767) : 41'sd0);
  assign xs = big ? (xb >>> 13) : (xb >>> 15);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      y_s5    <= xs[27:0];
      temp_s5 <= temp_s4;
    end
  end

  // Stage 6: the high-range part reports ten times the quotient; saturate.
  logic signed [31:0]        y32;
  logic signed [31:0]        z;
  logic signed [PRESS_W-1:0] press_next;

  assign y32 = {{4{y_s5[27]}}, y_s5};
  assign z   = big ? ((y32 <<< 3) + (y32 <<< 1)) : y32;

  always_comb begin
    if (z > PRESS_HI) begin
      press_next = PRESS_HI;
    end else if (z < PRESS_LO) begin
      press_next = PRESS_LO;
    end else begin
      press_next = z[24:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      result.pressure    <= press_next;
      result.temperature <= temp_s5;
    end
  end

  `PSC_ASSERT_IMP(a_stall_only_full, clk, rst, !en[0], &v)
  `PSC_ASSERT_NEXT(a_low_shift, clk, rst, v[3] && en[4] && !x_s4[40] && cfg.model == MODEL_LOW_RANGE, y_s5 == ($past(x_s4) >>> 15))
  `PSC_ASSERT_NEXT(a_mid_stage_holds, clk, rst, v[2] && !en[2], v[2] && $stable(q_s3))

endmodule

// ===== design/pressure_sensor_compensation.sv =====
// Top level of the pressure sensor second-order compensation pipeline.
//
// Usage: program the six calibration words and the model select through the
// write port (cfg_we, cfg_index, cfg_data) while no word is in flight. Then
// send raw conversion pairs on the sample channel; each accepted word yields
// exactly one word on the result channel, in order, carrying temperature in
// 0.01 degC and pressure in 0.01 mbar, both saturated.
// Five stages compute dT, the first-order terms and the corrections; six
// stages form D1 * SENS from two partial products, divide, scale and
// saturate. Throughput is one word per cycle while result is not stalled;
// every stage is registered and the widest multipliers are 25 by 25 bits.
// When result is stalled, words keep moving into empty stages, so bubbles
// close up; sample.ready falls only once all eleven stages hold a word.
// Nothing is lost or repeated across a stall.
// Reset clears every valid bit and sets all calibration words and the model
// select to zero.
module pressure_sensor_compensation import psc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  psc_in_if.sink                sample,
  psc_out_if.source             result
);

  psc_cfg_t cfg;
  logic     mid_valid;
  logic     mid_ready;
  psc_mid_t mid;

  psc_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  psc_temp_pipe u_temp_pipe (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .sample    (sample),
    .mid_valid (mid_valid),
    .mid_ready (mid_ready),
    .mid       (mid)
  );

  psc_press_pipe u_press_pipe (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .mid_valid (mid_valid),
    .mid_ready (mid_ready),
    .mid       (mid),
    .result    (result)
  );

endmodule
